// ===== design/cbpo_pkg.sv =====
// Shared types and constants for the circle/box push-out pipeline.
package cbpo_pkg;

	localparam int RW  = 31;   // radius, depth, distance and offset magnitude width
	localparam int SQW = 62;   // squared offset / squared radius width
	localparam int NW  = 18;   // Q1.16 normal width
	localparam int QW  = 18;   // quotient bits from the normal divider

	localparam logic [SQW:0]  EPS_SQ    = 63'd42;
	localparam logic [NW-1:0] ONE_Q16   = 18'd65536;
	localparam logic [RW-1:0] DEPTH_MAX = {RW{1'b1}};

	typedef enum logic [1:0] {
		FACE_LEFT,
		FACE_RIGHT,
		FACE_LOW,
		FACE_HIGH
	} face_t;

	// per-item sideband that rides along the sqrt and divide stages
	typedef struct packed {
		logic          tag;
		logic          outside;
		logic [RW-1:0] rad;
		logic [RW-1:0] idepth;
		face_t         face;
		logic          sx;
		logic          sz;
		logic [RW-1:0] ax;
		logic [RW-1:0] az;
	} ctx_t;

endpackage

// ===== design/cbpo_prep.sv =====
// Front stages: clamp, offsets, face distances, squares and branch decision.
module cbpo_prep #(
	parameter int CW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic signed [CW-1:0]   cx,
	input  logic signed [CW-1:0]   cz,
	input  logic [cbpo_pkg::RW-1:0] rad,
	input  logic signed [CW-1:0]   minx,
	input  logic signed [CW-1:0]   maxx,
	input  logic signed [CW-1:0]   minz,
	input  logic signed [CW-1:0]   maxz,
	input  logic                   tag,
	output logic                   valid,
	output cbpo_pkg::ctx_t         ctx,
	output logic [2*CW-1:0]        pt,
	output logic [cbpo_pkg::SQW-1:0] d2
);
	import cbpo_pkg::*;

	localparam int XW = (CW + 1 > 33) ? CW + 1 : 33;
	localparam int DW = ((CW + 1 > RW + 1) ? CW + 1 : RW + 1) + 1;

	function automatic logic signed [CW-1:0] clamp(input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] lo, input logic signed [CW-1:0] hi);
		if (p < lo)
			return lo;
		else if (p > hi)
			return hi;
		else
			return p;
	endfunction

	// stage 1
	logic                 valid_s1;
	logic signed [CW-1:0] qx_s1, qz_s1, cx_s1, cz_s1;
	logic signed [CW:0]   dx_s1, dz_s1, dl_s1, dr_s1, db_s1, df_s1;
	logic [RW-1:0]        rad_s1;
	logic                 tag_s1;

	logic signed [CW-1:0] qx_c, qz_c;
	assign qx_c = clamp(cx, minx, maxx);
	assign qz_c = clamp(cz, minz, maxz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		qx_s1  <= qx_c;
		qz_s1  <= qz_c;
		cx_s1  <= cx;
		cz_s1  <= cz;
		dx_s1  <= {cx[CW-1], cx} - {qx_c[CW-1], qx_c};
		dz_s1  <= {cz[CW-1], cz} - {qz_c[CW-1], qz_c};
		dl_s1  <= {cx[CW-1], cx} - {minx[CW-1], minx};
		dr_s1  <= {maxx[CW-1], maxx} - {cx[CW-1], cx};
		db_s1  <= {cz[CW-1], cz} - {minz[CW-1], minz};
		df_s1  <= {maxz[CW-1], maxz} - {cz[CW-1], cz};
		rad_s1 <= rad;
		tag_s1 <= tag;
	end

	// stage 2: magnitudes, far check, first level of the face minimum
	logic                 valid_s2;
	logic [RW-1:0]        ax_s2, az_s2;
	logic                 far_s2, sx_s2, sz_s2;
	logic signed [CW:0]   ma_s2, mb_s2;
	face_t                fa_s2, fb_s2;
	logic signed [CW-1:0] qx_s2, qz_s2, cx_s2, cz_s2;
	logic [RW-1:0]        rad_s2;
	logic                 tag_s2;

	logic [CW:0] ax_c, az_c;
	logic [XW-1:0] axe_c, aze_c;
	assign ax_c  = dx_s1[CW] ? (~dx_s1 + 1'b1) : dx_s1;
	assign az_c  = dz_s1[CW] ? (~dz_s1 + 1'b1) : dz_s1;
	assign axe_c = XW'(ax_c);
	assign aze_c = XW'(az_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		ax_s2  <= axe_c[RW-1:0];
		az_s2  <= aze_c[RW-1:0];
		far_s2 <= (axe_c >= (XW'(1) << 31)) || (aze_c >= (XW'(1) << 31));
		sx_s2  <= dx_s1[CW];
		sz_s2  <= dz_s1[CW];
		if (dr_s1 < dl_s1) begin
			ma_s2 <= dr_s1;
			fa_s2 <= FACE_RIGHT;
		end else begin
			ma_s2 <= dl_s1;
			fa_s2 <= FACE_LEFT;
		end
		if (df_s1 < db_s1) begin
			mb_s2 <= df_s1;
			fb_s2 <= FACE_HIGH;
		end else begin
			mb_s2 <= db_s1;
			fb_s2 <= FACE_LOW;
		end
		qx_s2  <= qx_s1;
		qz_s2  <= qz_s1;
		cx_s2  <= cx_s1;
		cz_s2  <= cz_s1;
		rad_s2 <= rad_s1;
		tag_s2 <= tag_s1;
	end

	// stage 3: squares, face pick, inside depth
	logic                 valid_s3;
	logic [SQW-1:0]       ax2_s3, az2_s3, r2_s3;
	logic [RW-1:0]        idepth_s3, ax_s3, az_s3, rad_s3;
	face_t                face_s3;
	logic                 far_s3, sx_s3, sz_s3, tag_s3;
	logic signed [CW-1:0] qx_s3, qz_s3, cx_s3, cz_s3;

	logic signed [CW:0]   m_c;
	face_t                f_c;
	logic signed [DW-1:0] sum_c;
	logic [RW-1:0]        idepth_c;

	always_comb begin
		if (mb_s2 < ma_s2) begin
			m_c = mb_s2;
			f_c = fb_s2;
		end else begin
			m_c = ma_s2;
			f_c = fa_s2;
		end
		sum_c = {{(DW-CW-1){m_c[CW]}}, m_c} + {{(DW-RW){1'b0}}, rad_s2};
		if (sum_c[DW-1])
			idepth_c = '0;
		else if (sum_c > $signed({{(DW-RW){1'b0}}, DEPTH_MAX}))
			idepth_c = DEPTH_MAX;
		else
			idepth_c = sum_c[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		ax2_s3    <= SQW'(ax_s2) * SQW'(ax_s2);
		az2_s3    <= SQW'(az_s2) * SQW'(az_s2);
		r2_s3     <= SQW'(rad_s2) * SQW'(rad_s2);
		idepth_s3 <= idepth_c;
		face_s3   <= f_c;
		ax_s3     <= ax_s2;
		az_s3     <= az_s2;
		rad_s3    <= rad_s2;
		far_s3    <= far_s2;
		sx_s3     <= sx_s2;
		sz_s3     <= sz_s2;
		tag_s3    <= tag_s2;
		qx_s3     <= qx_s2;
		qz_s3     <= qz_s2;
		cx_s3     <= cx_s2;
		cz_s3     <= cz_s2;
	end

	// stage 4: squared distance, branch and hit
	logic             valid_s4;
	ctx_t             ctx_s4;
	logic [2*CW-1:0]  pt_s4;
	logic [SQW-1:0]   d2_s4;

	logic [SQW:0] d2_c;
	logic         out_c, hit_c;
	assign d2_c  = {1'b0, ax2_s3} + {1'b0, az2_s3};
	assign out_c = d2_c > EPS_SQ;
	assign hit_c = !far_s3 && (!out_c || (d2_c < {1'b0, r2_s3}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else
			valid_s4 <= valid_s3 && hit_c;
	end

	always_ff @(posedge clk) begin
		ctx_s4.tag     <= tag_s3;
		ctx_s4.outside <= out_c;
		ctx_s4.rad     <= rad_s3;
		ctx_s4.idepth  <= idepth_s3;
		ctx_s4.face    <= face_s3;
		ctx_s4.sx      <= sx_s3;
		ctx_s4.sz      <= sz_s3;
		ctx_s4.ax      <= ax_s3;
		ctx_s4.az      <= az_s3;
		pt_s4          <= out_c ? {qx_s3, qz_s3} : {cx_s3, cz_s3};
		d2_s4          <= d2_c[SQW-1:0];
	end

	assign valid = valid_s4;
	assign ctx   = ctx_s4;
	assign pt    = pt_s4;
	assign d2    = d2_s4;

endmodule

// ===== design/cbpo_sqrt.sv =====
// Pipelined square root, one result bit per stage, then round to nearest.
module cbpo_sqrt #(
	parameter int CW = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  cbpo_pkg::ctx_t          in_ctx,
	input  logic [2*CW-1:0]         in_pt,
	input  logic [cbpo_pkg::SQW-1:0] in_d2,
	output logic                    valid,
	output cbpo_pkg::ctx_t          ctx,
	output logic [2*CW-1:0]         pt,
	output logic [cbpo_pkg::RW-1:0] rdist
);
	import cbpo_pkg::*;

	logic            vld_s  [RW+1];
	ctx_t            ctx_s  [RW+1];
	logic [2*CW-1:0] pt_s   [RW+1];
	logic [SQW-1:0]  rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];

	assign vld_s[0]  = in_valid;
	assign ctx_s[0]  = in_ctx;
	assign pt_s[0]   = in_pt;
	assign rem_s[0]  = in_d2;
	assign root_s[0] = '0;

	for (genvar i = 0; i < RW; i++) begin : g_bit
		localparam int K = RW - 1 - i;
		logic [SQW:0] trial;
		logic         take;
		// (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
		assign trial = ((SQW+1)'(root_s[i]) << (K + 1)) + ((SQW+1)'(1) << (2 * K));
		assign take  = {1'b0, rem_s[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			ctx_s[i+1] <= ctx_s[i];
			pt_s[i+1]  <= pt_s[i];
			if (take) begin
				rem_s[i+1]  <= rem_s[i] - trial[SQW-1:0];
				root_s[i+1] <= root_s[i] | (RW'(1) << K);
			end else begin
				rem_s[i+1]  <= rem_s[i];
				root_s[i+1] <= root_s[i];
			end
		end
	end

	// remainder above the floor root means the true root is past the half point
	logic            valid_s1;
	ctx_t            ctx_s1;
	logic [2*CW-1:0] pt_s1;
	logic [RW-1:0]   dist_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= vld_s[RW];
	end

	always_ff @(posedge clk) begin
		ctx_s1  <= ctx_s[RW];
		pt_s1   <= pt_s[RW];
		dist_s1 <= (rem_s[RW] > SQW'(root_s[RW])) ? root_s[RW] + RW'(1) : root_s[RW];
	end

	assign valid = valid_s1;
	assign ctx   = ctx_s1;
	assign pt    = pt_s1;
	assign rdist = dist_s1;

endmodule

// ===== design/cbpo_div.sv =====
// Two-lane restoring divider for the normal components, one quotient bit per stage.
module cbpo_div #(
	parameter int CW = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  cbpo_pkg::ctx_t          in_ctx,
	input  logic [2*CW-1:0]         in_pt,
	input  logic [cbpo_pkg::RW-1:0] in_dist,
	output logic                    valid,
	output cbpo_pkg::ctx_t          ctx,
	output logic [2*CW-1:0]         pt,
	output logic [cbpo_pkg::RW-1:0] rdist,
	output logic [cbpo_pkg::QW-1:0] qx,
	output logic [cbpo_pkg::QW-1:0] qz
);
	import cbpo_pkg::*;

	localparam int NMW = RW + 17;

	logic            vld_s  [QW+1];
	ctx_t            ctx_s  [QW+1];
	logic [2*CW-1:0] pt_s   [QW+1];
	logic [RW-1:0]   dist_s [QW+1];
	logic [NMW-1:0]  rx_s   [QW+1];
	logic [NMW-1:0]  rz_s   [QW+1];
	logic [QW-1:0]   qx_s   [QW+1];
	logic [QW-1:0]   qz_s   [QW+1];

	// numerator is |offset| * 2^16 plus half the divisor for round to nearest
	assign vld_s[0]  = in_valid;
	assign ctx_s[0]  = in_ctx;
	assign pt_s[0]   = in_pt;
	assign dist_s[0] = in_dist;
	assign rx_s[0]   = {1'b0, in_ctx.ax, 16'b0} + NMW'(in_dist >> 1);
	assign rz_s[0]   = {1'b0, in_ctx.az, 16'b0} + NMW'(in_dist >> 1);
	assign qx_s[0]   = '0;
	assign qz_s[0]   = '0;

	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int K = QW - 1 - i;
		logic [NMW+1:0] trial;
		logic           tx, tz;
		assign trial = (NMW+2)'(dist_s[i]) << K;
		assign tx    = (NMW+2)'(rx_s[i]) >= trial;
		assign tz    = (NMW+2)'(rz_s[i]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			ctx_s[i+1]  <= ctx_s[i];
			pt_s[i+1]   <= pt_s[i];
			dist_s[i+1] <= dist_s[i];
			rx_s[i+1]   <= tx ? rx_s[i] - trial[NMW-1:0] : rx_s[i];
			rz_s[i+1]   <= tz ? rz_s[i] - trial[NMW-1:0] : rz_s[i];
			qx_s[i+1]   <= qx_s[i] | (tx ? (QW'(1) << K) : '0);
			qz_s[i+1]   <= qz_s[i] | (tz ? (QW'(1) << K) : '0);
		end
	end

	assign valid = vld_s[QW];
	assign ctx   = ctx_s[QW];
	assign pt    = pt_s[QW];
	assign rdist = dist_s[QW];
	assign qx    = qx_s[QW];
	assign qz    = qz_s[QW];

endmodule

// ===== design/circle_box_push_out.sv =====
// Circle versus axis-aligned box contact on the ground plane, fully pipelined.
// One item is taken on every cycle that start is high; busy is always low.
// A contact leaves on strobe after its item has passed through 4 front
// stages (clamp, face distances, squares, branch), 32 for the square root
// (one root bit per stage plus rounding), 18 for the normal divider (one
// quotient bit per stage) and one output register. Items that give no
// contact simply produce no strobe; order is always kept.
module circle_box_push_out #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic [30:0]                   radius,
	input  logic signed [COORD_WIDTH-1:0] box_min_x,
	input  logic signed [COORD_WIDTH-1:0] box_max_x,
	input  logic signed [COORD_WIDTH-1:0] box_min_z,
	input  logic signed [COORD_WIDTH-1:0] box_max_z,
	input  logic                          moving_tag,
	output logic                          strobe,
	output logic signed [17:0]            normal_x,
	output logic signed [17:0]            normal_z,
	output logic [30:0]                   depth,
	output logic signed [COORD_WIDTH-1:0] contact_x,
	output logic signed [COORD_WIDTH-1:0] contact_z,
	output logic                          moving_flag
);
	import cbpo_pkg::*;

	localparam int CW = COORD_WIDTH;

	assign busy = 1'b0;

	logic            p_valid;
	ctx_t            p_ctx;
	logic [2*CW-1:0] p_pt;
	logic [SQW-1:0]  p_d2;

	cbpo_prep #(.CW(CW)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.cx       (center_x),
		.cz       (center_z),
		.rad      (radius),
		.minx     (box_min_x),
		.maxx     (box_max_x),
		.minz     (box_min_z),
		.maxz     (box_max_z),
		.tag      (moving_tag),
		.valid    (p_valid),
		.ctx      (p_ctx),
		.pt       (p_pt),
		.d2       (p_d2)
	);

	logic            s_valid;
	ctx_t            s_ctx;
	logic [2*CW-1:0] s_pt;
	logic [RW-1:0]   s_dist;

	cbpo_sqrt #(.CW(CW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (p_valid),
		.in_ctx   (p_ctx),
		.in_pt    (p_pt),
		.in_d2    (p_d2),
		.valid    (s_valid),
		.ctx      (s_ctx),
		.pt       (s_pt),
		.rdist    (s_dist)
	);

	logic            d_valid;
	ctx_t            d_ctx;
	logic [2*CW-1:0] d_pt;
	logic [RW-1:0]   d_dist;
	logic [QW-1:0]   d_qx, d_qz;

	cbpo_div #(.CW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_valid),
		.in_ctx   (s_ctx),
		.in_pt    (s_pt),
		.in_dist  (s_dist),
		.valid    (d_valid),
		.ctx      (d_ctx),
		.pt       (d_pt),
		.rdist    (d_dist),
		.qx       (d_qx),
		.qz       (d_qz)
	);

	logic [NW-1:0] qxs_c, qzs_c, nx_c, nz_c;
	logic [RW-1:0] depth_c;

	always_comb begin
		qxs_c = (d_qx > ONE_Q16) ? ONE_Q16 : d_qx;
		qzs_c = (d_qz > ONE_Q16) ? ONE_Q16 : d_qz;
		if (d_ctx.outside) begin
			nx_c    = d_ctx.sx ? (NW'(0) - qxs_c) : qxs_c;
			nz_c    = d_ctx.sz ? (NW'(0) - qzs_c) : qzs_c;
			depth_c = (d_dist > d_ctx.rad) ? '0 : d_ctx.rad - d_dist;
		end else begin
			depth_c = d_ctx.idepth;
			case (d_ctx.face)
				FACE_LEFT: begin
					nx_c = NW'(0) - ONE_Q16;
					nz_c = '0;
				end
				FACE_RIGHT: begin
					nx_c = ONE_Q16;
					nz_c = '0;
				end
				FACE_LOW: begin
					nx_c = '0;
					nz_c = NW'(0) - ONE_Q16;
				end
				default: begin
					nx_c = '0;
					nz_c = ONE_Q16;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe <= 1'b0;
		else
			strobe <= d_valid;
	end

	always_ff @(posedge clk) begin
		normal_x    <= nx_c;
		normal_z    <= nz_c;
		depth       <= depth_c;
		contact_x   <= d_pt[2*CW-1:CW];
		contact_z   <= d_pt[CW-1:0];
		moving_flag <= d_ctx.tag;
	end

	a_nx_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (normal_x <= 18'sd65536 && normal_x >= -18'sd65536))
		else $error("normal_x out of unit range");

	a_nz_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (normal_z <= 18'sd65536 && normal_z >= -18'sd65536))
		else $error("normal_z out of unit range");

	a_nonzero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(normal_x == 18'sd0 && normal_z == 18'sd0))
		else $error("contact with zero normal");

endmodule
